// File: hdl/reject_tracking_queue_macros.svh
// Assertion helpers for the reject tracking queue.
`ifndef REJECT_TRACKING_QUEUE_MACROS_SVH
`define REJECT_TRACKING_QUEUE_MACROS_SVH

// Checked only out of reset.
`define RTQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define RTQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rtq_pkg.sv
`timescale 1ns / 1ps

package rtq_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 4;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_JUDGE_TIMEOUT = 2'd0;
    localparam t_cfg_idx CFG_PUSH_PULSE    = 2'd1;
    localparam t_cfg_idx CFG_SENSOR_HOLD   = 2'd2;

    localparam t_cfg_data JUDGE_TIMEOUT_RST = 16'd1000;
    localparam t_cfg_data PUSH_PULSE_RST    = 16'd200;
    localparam t_cfg_data SENSOR_HOLD_RST   = 16'd50;
    localparam t_cfg_data HOLD_MAX          = 16'hFFFF;

    typedef enum logic [1:0] {
        CAM_IDLE     = 2'd0,
        CAM_CAPTURE  = 2'd1,
        CAM_WAIT_LOW = 2'd2
    } t_cam_phase;

    typedef enum logic [1:0] {
        PUSH_WAIT_RELEASE = 2'd0,
        PUSH_ARMED        = 2'd1,
        PUSH_FIRE         = 2'd2
    } t_push_phase;

endpackage

// File: hdl/rtq_if.sv
`timescale 1ns / 1ps

interface rtq_in_if;
    logic valid;
    logic ready;
    logic camera_ok;
    logic camera_ng;
    logic part_sensor;
    logic manual_push;

    modport source(output valid, output camera_ok, output camera_ng,
                   output part_sensor, output manual_push, input ready);
    modport sink(input valid, input camera_ok, input camera_ng,
                 input part_sensor, input manual_push, output ready);
endinterface

interface rtq_out_if;
    logic       valid;
    logic       ready;
    logic       cylinder_drive;
    logic [3:0] queue_count;
    logic       wrap_warning;
    logic       timeout_drop;
    logic       empty_push;

    modport source(output valid, output cylinder_drive, output queue_count,
                   output wrap_warning, output timeout_drop, output empty_push,
                   input ready);
    modport sink(input valid, input cylinder_drive, input queue_count,
                 input wrap_warning, input timeout_drop, input empty_push,
                 output ready);
endinterface

interface rtq_cfg_if;
    logic               valid;
    logic               ready;
    rtq_pkg::t_cfg_idx  index;
    rtq_pkg::t_cfg_data data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: hdl/reject_tracking_queue.sv
// A result word is presented in the cycle after its tick word is accepted. Throughput:
// one tick word per cycle unless o_out stalls; the head and next ring entries are
// prefetched through the two read ports each cycle, so a pop and a drop fit in one tick.
// Reset (synchronous, active low) clears indices, phases, counters, drive and the
// output valid, and loads the register defaults. Ring contents are not cleared.
`timescale 1ns / 1ps
`include "reject_tracking_queue_macros.svh"

module reject_tracking_queue #(
    parameter int RING_DEPTH = 16,
    parameter int TIME_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtq_in_if.sink    i_in,
    rtq_out_if.source o_out,
    rtq_cfg_if.sink   i_cfg
);

    import rtq_pkg::*;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int DATA_W = TIME_BITS + 1;
    localparam int QW     = (IDX_W < COUNT_W) ? COUNT_W : IDX_W;
    localparam int CW     = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] q_count(input logic [IDX_W-1:0] w,
                                                 input logic [IDX_W-1:0] r);
        logic [IDX_W:0] t;
        if (w >= r) begin
            t = {1'b0, w} - {1'b0, r};
        end else begin
            t = {1'b0, w} + (IDX_W+1)'(RING_DEPTH) - {1'b0, r};
        end
        return t[IDX_W-1:0];
    endfunction

    // configuration
    t_cfg_data r_judge_timeout;
    t_cfg_data r_push_pulse;
    t_cfg_data r_sensor_hold;

    // tick state
    logic [TIME_BITS-1:0] r_tick;
    logic [IDX_W-1:0]     r_wi;
    logic [IDX_W-1:0]     r_ri;
    t_cam_phase           r_cam;
    t_cam_phase           n_cam;
    t_push_phase          r_push;
    t_push_phase          n_push;
    t_cfg_data            r_hold;
    t_cfg_data            n_hold;
    t_cfg_data            r_pulse;
    t_cfg_data            n_pulse;
    logic                 r_drive;
    logic                 n_drive;
    logic [IDX_W-1:0]     n_wi;
    logic [IDX_W-1:0]     n_ri;

    // output register
    logic               r_out_valid;
    logic               r_out_drive;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_warn;
    logic               r_out_drop;
    logic               r_out_empty;

    logic               in_acc;
    logic               cam_wr;
    logic               hit;
    logic               pop;
    logic               empty;
    logic               warn;
    logic               drop;
    logic               head_v;
    logic [IDX_W-1:0]   q1;
    logic [IDX_W-1:0]   q2;
    logic [IDX_W-1:0]   ri1;
    logic [QW-1:0]      q_ext;
    t_cfg_data          hold_inc;

    logic               ring_we;
    logic [DATA_W-1:0]  ring_wdata;
    logic [IDX_W-1:0]   ring_raddr0;
    logic [IDX_W-1:0]   ring_raddr1;
    logic [DATA_W-1:0]  ring_rdata0;
    logic [DATA_W-1:0]  ring_rdata1;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    rtq_ring #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (DATA_W)
    ) u_ring (
        .i_clk    (i_clk),
        .i_we     (ring_we),
        .i_waddr  (r_wi),
        .i_wdata  (ring_wdata),
        .i_raddr0 (ring_raddr0),
        .i_raddr1 (ring_raddr1),
        .o_rdata0 (ring_rdata0),
        .o_rdata1 (ring_rdata1)
    );

    assign ring_we     = in_acc && cam_wr && i_rst_n;
    assign ring_wdata  = {i_in.camera_ok, r_tick};
    assign ring_raddr0 = i_rst_n ? n_ri : '0;
    assign ring_raddr1 = idx_inc(ring_raddr0);

    // camera FSM
    always_comb begin
        case (r_cam)
            CAM_IDLE:     n_cam = (i_in.camera_ok || i_in.camera_ng) ? CAM_CAPTURE : CAM_IDLE;
            CAM_CAPTURE:  n_cam = CAM_WAIT_LOW;
            CAM_WAIT_LOW: n_cam = (!i_in.camera_ok && !i_in.camera_ng) ? CAM_IDLE
                                                                       : CAM_WAIT_LOW;
            default:      n_cam = CAM_IDLE;
        endcase
    end

    always_comb begin
        cam_wr = (r_cam == CAM_CAPTURE);
    end

    // ring indices after the camera write, head verdict with forwarding
    always_comb begin
        n_wi   = cam_wr ? idx_inc(r_wi) : r_wi;
        warn   = cam_wr && (n_wi == r_ri);
        q1     = q_count(n_wi, r_ri);
        head_v = (cam_wr && (r_wi == r_ri)) ? i_in.camera_ok : ring_rdata0[TIME_BITS];
        hold_inc = (r_hold == HOLD_MAX) ? r_hold : r_hold + 1'b1;
        hit    = (r_push == PUSH_ARMED) && i_in.part_sensor && (hold_inc >= r_sensor_hold);
        pop    = hit && (q1 != '0);
        empty  = hit && (q1 == '0);
    end

    // push FSM
    always_comb begin
        case (r_push)
            PUSH_WAIT_RELEASE: n_push = i_in.part_sensor ? PUSH_WAIT_RELEASE : PUSH_ARMED;
            PUSH_ARMED: begin
                if (pop) begin
                    n_push = head_v ? PUSH_WAIT_RELEASE : PUSH_FIRE;
                end else if (empty) begin
                    n_push = PUSH_FIRE;
                end else begin
                    n_push = PUSH_ARMED;
                end
            end
            PUSH_FIRE:         n_push = PUSH_WAIT_RELEASE;
            default:           n_push = PUSH_WAIT_RELEASE;
        endcase
    end

    // push outputs, timeout, pulse timer
    always_comb begin
        logic [TIME_BITS-1:0] stamp;
        logic [TIME_BITS-1:0] age;
        n_hold  = r_hold;
        n_drive = r_drive;
        n_pulse = r_pulse;
        case (r_push)
            PUSH_WAIT_RELEASE: begin
                if (!i_in.part_sensor) begin
                    n_hold = '0;
                end
            end
            PUSH_ARMED: begin
                n_hold = i_in.part_sensor ? hold_inc : '0;
            end
            PUSH_FIRE: begin
                n_drive = 1'b1;
                n_pulse = r_push_pulse;
            end
            default: begin
                n_drive = 1'b0;
            end
        endcase

        ri1 = pop ? idx_inc(r_ri) : r_ri;
        q2  = q_count(n_wi, ri1);
        if (cam_wr && (r_wi == ri1)) begin
            stamp = r_tick;
        end else if (ri1 == r_ri) begin
            stamp = ring_rdata0[TIME_BITS-1:0];
        end else begin
            stamp = ring_rdata1[TIME_BITS-1:0];
        end
        age  = r_tick - stamp;
        drop = (q2 != '0) && (CW'(age) >= CW'(r_judge_timeout));
        n_ri = in_acc ? (drop ? idx_inc(ri1) : ri1) : r_ri;

        if (n_pulse == '0) begin
            n_drive = 1'b0;
        end else begin
            n_pulse = n_pulse - 1'b1;
        end
        if (i_in.manual_push) begin
            n_drive = 1'b1;
            n_pulse = r_push_pulse;
        end
        q_ext = QW'(q_count(n_wi, drop ? idx_inc(ri1) : ri1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_judge_timeout <= JUDGE_TIMEOUT_RST;
            r_push_pulse    <= PUSH_PULSE_RST;
            r_sensor_hold   <= SENSOR_HOLD_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_JUDGE_TIMEOUT: r_judge_timeout <= i_cfg.data;
                CFG_PUSH_PULSE:    r_push_pulse    <= i_cfg.data;
                CFG_SENSOR_HOLD:   r_sensor_hold   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_wi    <= '0;
            r_ri    <= '0;
            r_cam   <= CAM_IDLE;
            r_push  <= PUSH_WAIT_RELEASE;
            r_hold  <= '0;
            r_pulse <= '0;
            r_drive <= 1'b0;
        end else if (in_acc) begin
            r_tick  <= r_tick + 1'b1;
            r_wi    <= n_wi;
            r_ri    <= n_ri;
            r_cam   <= n_cam;
            r_push  <= n_push;
            r_hold  <= n_hold;
            r_pulse <= n_pulse;
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_drive <= n_drive;
            r_out_count <= q_ext[COUNT_W-1:0];
            r_out_warn  <= warn;
            r_out_drop  <= drop;
            r_out_empty <= empty;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cylinder_drive = r_out_drive;
    assign o_out.queue_count    = r_out_count;
    assign o_out.wrap_warning   = r_out_warn;
    assign o_out.timeout_drop   = r_out_drop;
    assign o_out.empty_push     = r_out_empty;

    `RTQ_ASSERT_RST(a_pulse_drives, i_clk, i_rst_n, (r_pulse != '0) |-> r_drive, "pulse running with drive off")
    `RTQ_ASSERT_RST(a_drop_empty_excl, i_clk, i_rst_n, r_out_valid |-> !(r_out_drop && r_out_empty), "drop and empty push together")
    `RTQ_ASSERT_RST(a_wrap_empties, i_clk, i_rst_n, (r_out_valid && r_out_warn) |-> (r_out_count == '0), "ring not empty after wrap")
    `RTQ_ASSERT_RST(a_accept_result, i_clk, i_rst_n, in_acc |=> r_out_valid, "accepted tick without result")
    `RTQ_ASSERT_ALWAYS(a_reset_clears, i_clk, (!i_rst_n) |=> (!r_out_valid && (r_ri == '0) && (r_wi == '0)), "reset did not clear")

endmodule

// File: hdl/rtq_ring.sv
`timescale 1ns / 1ps

module rtq_ring #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [DATA_W-1:0]        o_rdata0,
    output logic [DATA_W-1:0]        o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata0;
    logic [DATA_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first on both read ports
    always_ff @(posedge i_clk) begin
        r_rdata0 <= (i_we && (i_waddr == i_raddr0)) ? i_wdata : r_mem[i_raddr0];
        r_rdata1 <= (i_we && (i_waddr == i_raddr1)) ? i_wdata : r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rtq_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SHOW_LIMIT  = 40;

    typedef struct packed {
        bit camera_ok;
        bit camera_ng;
        bit part_sensor;
        bit manual_push;
    } tick_t;

    typedef struct packed {
        logic       cylinder_drive;
        logic [3:0] queue_count;
        logic       wrap_warning;
        logic       timeout_drop;
        logic       empty_push;
    } outcome_t;

    class tick_scoreboard;
        t_cfg_data   judge_timeout;
        t_cfg_data   pulse_len;
        t_cfg_data   hold_len;
        bit [15:0]   now_tick;
        bit          verdicts [16];
        bit [15:0]   stamps [16];
        bit [3:0]    wr_idx;
        bit [3:0]    rd_idx;
        t_cam_phase  cam_phase;
        t_push_phase push_phase;
        bit [15:0]   hold_cnt;
        bit [15:0]   pulse_cnt;
        bit          drive_on;
        outcome_t    pending_outcomes [$];
        int          mismatches;

        function new();
            judge_timeout = JUDGE_TIMEOUT_RST;
            pulse_len     = PUSH_PULSE_RST;
            hold_len      = SENSOR_HOLD_RST;
            now_tick      = '0;
            wr_idx        = '0;
            rd_idx        = '0;
            cam_phase     = CAM_IDLE;
            push_phase    = PUSH_WAIT_RELEASE;
            hold_cnt      = '0;
            pulse_cnt     = '0;
            drive_on      = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_cfg_data val);
            case (idx)
                CFG_JUDGE_TIMEOUT: judge_timeout = val;
                CFG_PUSH_PULSE:    pulse_len     = val;
                CFG_SENSOR_HOLD:   hold_len      = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function void note_tick(tick_t t);
            outcome_t  o;
            bit [15:0] age;
            o = '0;
            case (cam_phase)
                CAM_IDLE: begin
                    if (t.camera_ok || t.camera_ng) cam_phase = CAM_CAPTURE;
                end
                CAM_CAPTURE: begin
                    verdicts[wr_idx] = t.camera_ok;
                    stamps[wr_idx]   = now_tick;
                    wr_idx = wr_idx + 4'd1;
                    if (wr_idx == rd_idx) o.wrap_warning = 1'b1;
                    cam_phase = CAM_WAIT_LOW;
                end
                CAM_WAIT_LOW: begin
                    if (!t.camera_ok && !t.camera_ng) cam_phase = CAM_IDLE;
                end
                default: cam_phase = CAM_IDLE;
            endcase

            case (push_phase)
                PUSH_WAIT_RELEASE: begin
                    if (!t.part_sensor) begin
                        hold_cnt   = '0;
                        push_phase = PUSH_ARMED;
                    end
                end
                PUSH_ARMED: begin
                    if (t.part_sensor) begin
                        if (hold_cnt != HOLD_MAX) hold_cnt = hold_cnt + 16'd1;
                        if (hold_cnt >= hold_len) begin
                            if (wr_idx != rd_idx) begin
                                push_phase = verdicts[rd_idx] ? PUSH_WAIT_RELEASE : PUSH_FIRE;
                                rd_idx = rd_idx + 4'd1;
                            end else begin
                                o.empty_push = 1'b1;
                                push_phase   = PUSH_FIRE;
                            end
                        end
                    end else begin
                        hold_cnt = '0;
                    end
                end
                PUSH_FIRE: begin
                    drive_on   = 1'b1;
                    pulse_cnt  = pulse_len;
                    push_phase = PUSH_WAIT_RELEASE;
                end
                default: begin
                    push_phase = PUSH_WAIT_RELEASE;
                    drive_on   = 1'b0;
                end
            endcase

            if (wr_idx != rd_idx) begin
                age = now_tick - stamps[rd_idx];
                if (age >= judge_timeout) begin
                    rd_idx = rd_idx + 4'd1;
                    o.timeout_drop = 1'b1;
                end
            end

            if (pulse_cnt == 0) drive_on = 1'b0;
            else pulse_cnt = pulse_cnt - 16'd1;

            if (t.manual_push) begin
                drive_on  = 1'b1;
                pulse_cnt = pulse_len;
            end

            now_tick = now_tick + 16'd1;
            o.cylinder_drive = drive_on;
            o.queue_count    = wr_idx - rd_idx;
            pending_outcomes.push_back(o);
        endfunction

        task report_mismatch(string what, logic [3:0] got, logic [3:0] want);
            if (mismatches < SHOW_LIMIT)
                $display("tb_top: mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_outcome(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected word", 4'h0, 4'h0);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.cylinder_drive !== want.cylinder_drive)
                    report_mismatch("cylinder_drive", got.cylinder_drive, want.cylinder_drive);
                if (got.queue_count !== want.queue_count)
                    report_mismatch("queue_count", got.queue_count, want.queue_count);
                if (got.wrap_warning !== want.wrap_warning)
                    report_mismatch("wrap_warning", got.wrap_warning, want.wrap_warning);
                if (got.timeout_drop !== want.timeout_drop)
                    report_mismatch("timeout_drop", got.timeout_drop, want.timeout_drop);
                if (got.empty_push !== want.empty_push)
                    report_mismatch("empty_push", got.empty_push, want.empty_push);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    rtq_in_if  in_if ();
    rtq_out_if out_if ();
    rtq_cfg_if cfg_if ();

    reject_tracking_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    tick_scoreboard sb = new();

    int send_idle_pct = 24;
    int recv_idle_pct = 63;
    int send_calm     = 0;

    int cam_busy    = 0;
    int cam_idle    = 0;
    int cam_kind    = 0;
    int cam_spacing = 4;
    int sen_left    = 0;
    int cur_hold    = 50;
    bit sen_level   = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_tick(tick_t t);
        in_if.valid       <= 1'b1;
        in_if.camera_ok   <= t.camera_ok;
        in_if.camera_ng   <= t.camera_ng;
        in_if.part_sensor <= t.part_sensor;
        in_if.manual_push <= t.manual_push;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        sb.note_tick(t);
    endtask

    task automatic sender_pause();
        if (send_calm != 0) send_calm--;
        else if ($urandom_range(0, 199) == 0) send_calm = 30;
        if (send_calm == 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic send_seq(bit [63:0] seq, int n);
        for (int k = 0; k < n; k++) begin
            send_tick(tick_t'(seq[(n - 1 - k) * 4 +: 4]));
            sender_pause();
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(t_cfg_data tmo, t_cfg_data pls, t_cfg_data hld);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        write_reg(CFG_JUDGE_TIMEOUT, tmo);
        write_reg(CFG_PUSH_PULSE, pls);
        write_reg(CFG_SENSOR_HOLD, hld);
        cfg_if.valid <= 1'b0;
        cur_hold = hld;
    endtask

    // Mostly well-formed camera pulses and sensor hold windows, with some raw noise.
    function automatic tick_t make_tick();
        tick_t t;
        int    n;
        t = '0;
        if ($urandom_range(0, 9) == 0) begin
            t = tick_t'(4'($urandom_range(0, 15)));
        end else begin
            if (cam_busy == 0 && cam_idle == 0) begin
                cam_busy = $urandom_range(1, 4);
                cam_kind = $urandom_range(0, 3);
                cam_idle = $urandom_range(1, cam_spacing);
            end
            if (cam_busy != 0) begin
                t.camera_ok = (cam_kind == 0 || cam_kind == 2) ||
                              (cam_kind == 3 && $urandom_range(0, 1) == 1);
                t.camera_ng = (cam_kind != 0);
                cam_busy--;
            end else begin
                cam_idle--;
            end
            if (sen_left == 0) begin
                sen_level = !sen_level;
                if (sen_level) begin
                    n = cur_hold + $urandom_range(0, 3);
                    if ($urandom_range(0, 4) == 0) n = n - 2;
                    if (n < 1) n = 1;
                    if (n > 300) n = 300;
                end else begin
                    n = $urandom_range(1, 4);
                end
                sen_left = n;
            end
            t.part_sensor = sen_level;
            sen_left--;
            t.manual_push = ($urandom_range(0, 49) == 0);
        end
        return t;
    endfunction

    task automatic run_phase(t_cfg_data tmo, t_cfg_data pls, t_cfg_data hld,
                             int spacing, int n);
        load_settings(tmo, pls, hld);
        cam_spacing = spacing;
        cam_busy    = 0;
        cam_idle    = 0;
        sen_left    = 0;
        sen_level   = 1'b1;
        for (int k = 0; k < n; k++) begin
            send_tick(make_tick());
            if (k == n / 2 || $urandom_range(0, 249) == 0) begin
                // hold off until every word in flight has come back
                in_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end else begin
                sender_pause();
            end
        end
    endtask

    initial begin
        outcome_t got;
        int       recv_calm;
        recv_calm    = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.cylinder_drive = out_if.cylinder_drive;
                got.queue_count    = out_if.queue_count;
                got.wrap_warning   = out_if.wrap_warning;
                got.timeout_drop   = out_if.timeout_drop;
                got.empty_push     = out_if.empty_push;
                sb.check_outcome(got);
            end
            if (recv_calm != 0) recv_calm--;
            else if ($urandom_range(0, 299) == 0) recv_calm = 40;
            out_if.ready <= !(recv_calm == 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.camera_ok   <= 1'b0;
        in_if.camera_ng   <= 1'b0;
        in_if.part_sensor <= 1'b0;
        in_if.manual_push <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_JUDGE_TIMEOUT;
        cfg_if.data       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, then zero times, then short times
        send_seq(64'h0F01, 4);
        load_settings(16'd0, 16'd0, 16'd0);
        send_seq(64'h042088020201, 12);
        load_settings(16'd6, 16'd3, 16'd2);
        send_seq(64'h88040022022, 11);

        send_idle_pct = 24;
        recv_idle_pct = 63;
        run_phase(JUDGE_TIMEOUT_RST, PUSH_PULSE_RST, SENSOR_HOLD_RST, 8, 200);
        run_phase(16'd0, 16'd0, 16'd0, 3, 200);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 2, 200);

        send_idle_pct = 63;
        recv_idle_pct = 24;
        run_phase(t_cfg_data'($urandom_range(10, 120)), t_cfg_data'($urandom_range(0, 8)),
                  t_cfg_data'($urandom_range(0, 6)), 4, 200);
        run_phase(16'd200, 16'd5, 16'd3, 2, 200);
        run_phase(t_cfg_data'($urandom_range(1, 60)), t_cfg_data'($urandom_range(0, 4)),
                  t_cfg_data'($urandom_range(0, 3)), 3, 200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'hFFFF, 16'd0, 16'd1, 2, 200);
        run_phase(t_cfg_data'($urandom_range(20, 300)), t_cfg_data'($urandom_range(0, 12)),
                  t_cfg_data'($urandom_range(0, 8)), 5, 200);

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
